### rtl/ptb_pkg.sv
// Shared types and codes for the periodic timer bank.
package ptb_pkg;

    // Input opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SETUP     = 3'd1;
    localparam logic [2:0] OP_DELAY_ONE = 3'd2;
    localparam logic [2:0] OP_DELAY_ALL = 3'd3;
    localparam logic [2:0] OP_STOP      = 3'd4;
    localparam logic [2:0] OP_RESTART   = 3'd5;

    // Result kinds and status codes
    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Most fire beats one tick reports
    localparam logic [4:0] RESULT_CAP = 5'd16;

    // Reset value of the delay limit register
    localparam logic [31:0] DELAY_LIMIT_RESET = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_DELAYED = 2'd1,
        MODE_STOPPED = 2'd2
    } mode_t;

    // Write of the last-fire / wake time memory
    typedef struct packed {
        logic        en;
        logic [31:0] data;
    } time_wr_t;

    // Write of the period / late limit memory
    typedef struct packed {
        logic        en;
        logic [31:0] period;
        logic [31:0] late;
    } param_wr_t;

    // Update of the per-timer mode and registered flags
    typedef struct packed {
        logic  en;
        mode_t mode;
        logic  set_reg;
    } mode_wr_t;

    // Outcome of evaluating one scanned entry on a tick
    typedef struct packed {
        logic fire;
        logic timed_out;
        logic to_ready;
        logic upd_time;
    } eval_t;

endpackage

### rtl/ptb_timer_store.sv
// Timer entry storage: period/late and time memories plus mode and registered flags.
module ptb_timer_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    // synchronous read port, registered output
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [31:0]        rd_period,
    output logic [31:0]        rd_late,
    output logic [31:0]        rd_time,
    // entry address for writes and flag lookup
    input  logic [AW-1:0]      ent_addr,
    input  ptb_pkg::time_wr_t  time_wr,
    input  ptb_pkg::param_wr_t param_wr,
    input  ptb_pkg::mode_wr_t  mode_wr,
    output ptb_pkg::mode_t     q_mode,
    output logic               q_registered
);
    import ptb_pkg::*;

    logic [63:0] param_mem [DEPTH];
    logic [31:0] time_mem  [DEPTH];
    logic [63:0] param_rd_reg;
    logic [31:0] time_rd_reg;

    mode_t      mode_reg [DEPTH];
    logic [DEPTH-1:0] registered_reg;

    // Write and read the period/late memory
    always_ff @(posedge clk)
    begin
        if (param_wr.en)
        begin
            param_mem[ent_addr] <= {param_wr.late, param_wr.period};
        end
        if (rd_en)
        begin
            param_rd_reg <= param_mem[rd_addr];
        end
    end

    // Write and read the time memory
    always_ff @(posedge clk)
    begin
        if (time_wr.en)
        begin
            time_mem[ent_addr] <= time_wr.data;
        end
        if (rd_en)
        begin
            time_rd_reg <= time_mem[rd_addr];
        end
    end

    assign rd_period = param_rd_reg[31:0];
    assign rd_late   = param_rd_reg[63:32];
    assign rd_time   = time_rd_reg;

    // Hold mode and registered flags in flops so reset clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                mode_reg[i] <= MODE_READY;
            end
            registered_reg <= '0;
        end
        else if (mode_wr.en)
        begin
            mode_reg[ent_addr] <= mode_wr.mode;
            if (mode_wr.set_reg)
            begin
                registered_reg[ent_addr] <= 1'b1;
            end
        end
    end

    assign q_mode       = mode_reg[ent_addr];
    assign q_registered = registered_reg[ent_addr];

endmodule

### rtl/ptb_entry_eval.sv
// Tick evaluation of one timer entry: firing, lateness and wake test.
module ptb_entry_eval (
    input  logic           is_reg,
    input  ptb_pkg::mode_t mode,
    input  logic [31:0]    last_time,
    input  logic [31:0]    period,
    input  logic [31:0]    late,
    input  logic [31:0]    now,
    input  logic [31:0]    delay_limit,
    output ptb_pkg::eval_t ev
);
    import ptb_pkg::*;

    logic [31:0] elapsed;

    // Wrapped elapsed time since last firing, or since wake time when delayed
    assign elapsed = now - last_time;

    always_comb
    begin
        ev.fire      = is_reg && (mode == MODE_READY) && (elapsed >= period);
        ev.timed_out = elapsed > late;
        ev.to_ready  = is_reg && (mode == MODE_DELAYED) && (elapsed < delay_limit);
        ev.upd_time  = ev.fire || ev.to_ready;
    end

endmodule

### rtl/periodic_timer_bank.sv
// Periodic timer bank: command sequencer, tick scan and result output register.
// Tick: one entry read per cycle from the timer memories while the scan is not stalled
//   by a full output register; the held fire beat goes out last from the flush state.
// Delay all sweeps every entry in turn, then sends its status beat; a rejected delay skips the sweep.
// Setup, delay one, stop and restart act in the response state, which loads the result beat.
// Reset (rst_n low, async) clears modes to ready, registered flags and control;
//   delay_limit returns to 0x7FFFFFFF; the memories are not cleared.
module periodic_timer_bank #(
    parameter int TIMER_COUNT = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: timer_index[3:0], now_us[35:4], period_us[67:36],
    //        late_limit_us[99:68], delay_us[131:100], zero pad [135:132]
    input  logic [135:0] s_tdata,
    // tuser: opcode[2:0]
    input  logic [2:0]   s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: fired_index[3:0], timed_out[4], status[5], zero pad [7:6]
    output logic [7:0]   m_tdata,
    // tuser: kind[0]
    output logic         m_tuser,
    output logic         m_tlast,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);
    import ptb_pkg::*;

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam logic [CW-1:0] CNT_N    = CW'(TIMER_COUNT);
    localparam logic [CW-1:0] CNT_LAST = CW'(TIMER_COUNT - 1);
    localparam logic [31:0]   TC32     = 32'(TIMER_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_SWEEP,
        S_RESP
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] delay_limit_reg;

    // latched item
    logic [2:0]  op_reg;
    logic [3:0]  idx_reg;
    logic [31:0] now_reg;
    logic [31:0] per_reg;
    logic [31:0] late_reg;
    logic [31:0] wake_reg;
    logic        reject_reg;

    // scan / sweep control
    logic [CW-1:0] iss_idx_reg, iss_idx_next;
    logic          proc_vld_reg, proc_vld_next;
    logic [AW-1:0] proc_idx_reg, proc_idx_next;
    logic [4:0]    fire_cnt_reg, fire_cnt_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [3:0]    pend_idx_reg, pend_idx_next;
    logic          pend_to_reg, pend_to_next;

    // output register
    logic       out_vld_reg;
    logic [3:0] out_idx_reg;
    logic       out_to_reg;
    logic       out_status_reg;
    logic       out_kind_reg;
    logic       out_last_reg;
    logic       out_load;
    logic [3:0] out_idx_next;
    logic       out_to_next;
    logic       out_status_next;
    logic       out_kind_next;
    logic       out_last_next;
    logic       out_free;

    // store interface
    logic          rd_en;
    logic [31:0]   rd_period;
    logic [31:0]   rd_late;
    logic [31:0]   rd_time;
    logic [AW-1:0] ent_addr;
    time_wr_t      time_wr;
    param_wr_t     param_wr;
    mode_wr_t      mode_wr;
    mode_t         q_mode;
    logic          q_registered;
    eval_t         ev;

    logic accept;
    logic idx_ok;
    logic report;
    logic stall;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_vld_reg || m_tready;
    assign idx_ok   = {28'd0, idx_reg} < TC32;
    assign report   = proc_vld_reg && ev.fire && (fire_cnt_reg != RESULT_CAP);
    assign stall    = (state_reg == S_SCAN) && report && pend_vld_reg && !out_free;

    ptb_timer_store #(
        .DEPTH (TIMER_COUNT),
        .AW    (AW)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (rd_en),
        .rd_addr      (iss_idx_reg[AW-1:0]),
        .rd_period    (rd_period),
        .rd_late      (rd_late),
        .rd_time      (rd_time),
        .ent_addr     (ent_addr),
        .time_wr      (time_wr),
        .param_wr     (param_wr),
        .mode_wr      (mode_wr),
        .q_mode       (q_mode),
        .q_registered (q_registered)
    );

    ptb_entry_eval u_eval (
        .is_reg      (q_registered),
        .mode        (q_mode),
        .last_time   (rd_time),
        .period      (rd_period),
        .late        (rd_late),
        .now         (now_reg),
        .delay_limit (delay_limit_reg),
        .ev          (ev)
    );

    // Pick the entry that writes and flag lookups address
    always_comb
    begin
        case (state_reg)
            S_SCAN:  ent_addr = proc_idx_reg;
            S_SWEEP: ent_addr = iss_idx_reg[AW-1:0];
            default: ent_addr = AW'(idx_reg);
        endcase
    end

    // Sequence commands, tick scan and result beats
    always_comb
    begin
        state_next      = state_reg;
        iss_idx_next    = iss_idx_reg;
        proc_vld_next   = proc_vld_reg;
        proc_idx_next   = proc_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        pend_to_next    = pend_to_reg;
        rd_en           = 1'b0;
        time_wr         = '0;
        param_wr        = '0;
        mode_wr         = '0;
        out_load        = 1'b0;
        out_kind_next   = KIND_FIRE;
        out_idx_next    = pend_idx_reg;
        out_to_next     = pend_to_reg;
        out_status_next = STATUS_OK;
        out_last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    iss_idx_next  = '0;
                    proc_vld_next = 1'b0;
                    fire_cnt_next = '0;
                    pend_vld_next = 1'b0;
                    case (s_tuser)
                        OP_TICK:      state_next = S_SCAN;
                        OP_SETUP,
                        OP_DELAY_ONE,
                        OP_STOP,
                        OP_RESTART:   state_next = S_RESP;
                        OP_DELAY_ALL:
                        begin
                            if ((s_tdata[131:100] == 32'd0) ||
                                (s_tdata[131:100] > delay_limit_reg))
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        default:      state_next = S_IDLE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    // write back the entry whose read data is held in the read registers
                    if (proc_vld_reg)
                    begin
                        time_wr.en   = ev.upd_time;
                        time_wr.data = now_reg;
                        mode_wr.en   = ev.to_ready;
                        mode_wr.mode = MODE_READY;
                        if (report)
                        begin
                            if (pend_vld_reg)
                            begin
                                out_load = 1'b1;
                            end
                            pend_vld_next = 1'b1;
                            pend_idx_next = 4'(proc_idx_reg);
                            pend_to_next  = ev.timed_out;
                            fire_cnt_next = fire_cnt_reg + 5'd1;
                        end
                    end
                    // issue the next read
                    if (iss_idx_reg < CNT_N)
                    begin
                        rd_en         = 1'b1;
                        proc_vld_next = 1'b1;
                        proc_idx_next = iss_idx_reg[AW-1:0];
                        iss_idx_next  = iss_idx_reg + CW'(1);
                    end
                    else
                    begin
                        proc_vld_next = 1'b0;
                        if (!proc_vld_reg)
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
            end

            S_FLUSH:
            begin
                // send the held fire beat as the final one
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            S_SWEEP:
            begin
                // delay every registered timer that is not stopped
                if (q_registered && (q_mode != MODE_STOPPED))
                begin
                    mode_wr.en   = 1'b1;
                    mode_wr.mode = MODE_DELAYED;
                    time_wr.en   = 1'b1;
                    time_wr.data = wake_reg;
                end
                iss_idx_next = iss_idx_reg + CW'(1);
                if (iss_idx_reg == CNT_LAST)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_STATUS;
                    out_idx_next    = 4'd0;
                    out_to_next     = 1'b0;
                    out_status_next = ((op_reg == OP_DELAY_ONE) || (op_reg == OP_DELAY_ALL))
                                      ? (reject_reg ? STATUS_REJECT : STATUS_OK)
                                      : STATUS_OK;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    if (idx_ok)
                    begin
                        case (op_reg)
                            OP_SETUP:
                            begin
                                param_wr.en     = 1'b1;
                                param_wr.period = per_reg;
                                param_wr.late   = late_reg;
                                time_wr.en      = 1'b1;
                                time_wr.data    = 32'd0;
                                mode_wr.en      = 1'b1;
                                mode_wr.mode    = MODE_READY;
                                mode_wr.set_reg = 1'b1;
                            end
                            OP_DELAY_ONE:
                            begin
                                if (!reject_reg && (q_mode != MODE_STOPPED))
                                begin
                                    mode_wr.en   = 1'b1;
                                    mode_wr.mode = MODE_DELAYED;
                                    time_wr.en   = 1'b1;
                                    time_wr.data = wake_reg;
                                end
                            end
                            OP_STOP:
                            begin
                                mode_wr.en   = 1'b1;
                                mode_wr.mode = MODE_STOPPED;
                                time_wr.en   = 1'b1;
                                time_wr.data = 32'd0;
                            end
                            OP_RESTART:
                            begin
                                mode_wr.en   = 1'b1;
                                mode_wr.mode = MODE_READY;
                                time_wr.en   = 1'b1;
                                time_wr.data = now_reg;
                            end
                            default:
                            begin
                                mode_wr.en = 1'b0;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, control counters and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            delay_limit_reg <= DELAY_LIMIT_RESET;
            iss_idx_reg     <= '0;
            proc_vld_reg    <= 1'b0;
            fire_cnt_reg    <= '0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_idx_reg  <= iss_idx_next;
            proc_vld_reg <= proc_vld_next;
            fire_cnt_reg <= fire_cnt_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_wr_en)
            begin
                delay_limit_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Latch the item and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            idx_reg    <= s_tdata[3:0];
            now_reg    <= s_tdata[35:4];
            per_reg    <= s_tdata[67:36];
            late_reg   <= s_tdata[99:68];
            wake_reg   <= s_tdata[35:4] + s_tdata[131:100];
            reject_reg <= (s_tdata[131:100] == 32'd0) ||
                          (s_tdata[131:100] > delay_limit_reg);
        end
        proc_idx_reg <= proc_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_to_reg  <= pend_to_next;
        if (out_load)
        begin
            out_kind_reg   <= out_kind_next;
            out_idx_reg    <= out_idx_next;
            out_to_reg     <= out_to_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_to_reg, out_idx_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A new beat never overwrites one the sink has not taken
    assert property (@(posedge clk) disable iff (!rst_n) out_load |-> out_free)
        else $error("output beat overwritten");

    // Reported firings stay within the cap
    assert property (@(posedge clk) disable iff (!rst_n) fire_cnt_reg <= RESULT_CAP)
        else $error("fire count above cap");

    // No fire beat is left held once the block is ready again
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !pend_vld_reg)
        else $error("held fire beat while idle");

    // A stalled scan keeps its read data and position
    assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (proc_vld_reg && $stable(iss_idx_reg) && $stable(proc_idx_reg)))
        else $error("scan moved during stall");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the periodic timer bank: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import ptb_pkg::*;

    localparam int NUM_TIMERS = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS = 48;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Row count marker: predicted instead of typed
    localparam int ROW_PREDICTED = -1;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [31:0] now_us;
        logic [31:0] period_us;
        logic [31:0] late_us;
        logic [31:0] delay_us;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] idx;
        logic       timed_out;
        logic       status;
        logic       last;
    } beat_t;

    typedef struct {
        cmd_t c;
        int   n;
        logic st;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en = 1'b0;
    logic [31:0]  cfg_wr_data = '0;

    // Shadow copy of the timer bank
    mode_t       tm_mode [NUM_TIMERS];
    logic        tm_reg [NUM_TIMERS];
    logic [31:0] tm_period [NUM_TIMERS];
    logic [31:0] tm_late [NUM_TIMERS];
    logic [31:0] tm_last [NUM_TIMERS];
    logic [31:0] tm_limit;

    beat_t pending_beats [$];
    beat_t step_beats [$];
    row_t  dir_rows [$];
    int    fail_count = 0;
    bit    steady = 1'b0;
    int    rx_wait = 0;
    logic [31:0] run_now = '0;

    periodic_timer_bank #(
        .TIMER_COUNT (NUM_TIMERS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the result beats one command causes and advance the shadow bank
    task automatic predict_timer_results(input cmd_t c);
        logic [31:0] elapsed;
        int fired;
        fired = 0;
        step_beats.delete();
        case (c.op)
            OP_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (tm_reg[i])
                    begin
                        elapsed = c.now_us - tm_last[i];
                        if (tm_mode[i] == MODE_READY)
                        begin
                            if (elapsed >= tm_period[i])
                            begin
                                tm_last[i] = c.now_us;
                                if (fired < int'(RESULT_CAP))
                                begin
                                    step_beats.push_back({KIND_FIRE, 4'(i),
                                        elapsed > tm_late[i], STATUS_OK, 1'b0});
                                    fired++;
                                end
                            end
                        end
                        else if (tm_mode[i] == MODE_DELAYED)
                        begin
                            if (elapsed < tm_limit)
                            begin
                                tm_last[i] = c.now_us;
                                tm_mode[i] = MODE_READY;
                            end
                        end
                    end
                end
                if (fired > 0)
                    step_beats[fired - 1].last = 1'b1;
            end
            OP_SETUP:
            begin
                tm_period[c.idx] = c.period_us;
                tm_late[c.idx] = c.late_us;
                tm_reg[c.idx] = 1'b1;
                tm_mode[c.idx] = MODE_READY;
                tm_last[c.idx] = '0;
                step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, STATUS_OK, 1'b1});
            end
            OP_DELAY_ONE, OP_DELAY_ALL:
            begin
                if (c.delay_us == 0 || c.delay_us > tm_limit)
                    step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, STATUS_REJECT, 1'b1});
                else
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (((c.op == OP_DELAY_ONE && i == int'(c.idx)) ||
                             (c.op == OP_DELAY_ALL && tm_reg[i])) &&
                            tm_mode[i] != MODE_STOPPED)
                        begin
                            tm_mode[i] = MODE_DELAYED;
                            tm_last[i] = c.now_us + c.delay_us;
                        end
                    end
                    step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, STATUS_OK, 1'b1});
                end
            end
            OP_STOP:
            begin
                tm_mode[c.idx] = MODE_STOPPED;
                tm_last[c.idx] = '0;
                step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, STATUS_OK, 1'b1});
            end
            OP_RESTART:
            begin
                tm_mode[c.idx] = MODE_READY;
                tm_last[c.idx] = c.now_us;
                step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, STATUS_OK, 1'b1});
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one command, hold it until accepted, then queue what it should produce
    task automatic send_item(input cmd_t c, input int typed_n, input logic typed_st);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= {4'd0, c.delay_us, c.late_us, c.period_us, c.now_us, c.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_timer_results(c);
        if (typed_n != ROW_PREDICTED)
        begin
            step_beats.delete();
            if (typed_n > 0)
                step_beats.push_back({KIND_STATUS, 4'd0, 1'b0, typed_st, 1'b1});
        end
        foreach (step_beats[k])
            pending_beats.push_back(step_beats[k]);
    endtask

    // Drain, let the block settle, then write the delay limit
    task automatic write_delay_limit(input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= $urandom;
        tm_limit = value;
    endtask

    task automatic add_row(input logic [2:0] op, input logic [3:0] idx,
                           input logic [31:0] now_us, input logic [31:0] period_us,
                           input logic [31:0] late_us, input logic [31:0] delay_us,
                           input int n, input logic st);
        row_t r;
        r.c = {op, idx, now_us, period_us, late_us, delay_us};
        r.n = n;
        r.st = st;
        dir_rows.push_back(r);
    endtask

    // Build one random command; mostly in-range traffic on a running clock, some noise
    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        c = {3'($urandom_range(0, 7)), 4'($urandom), $urandom, $urandom, $urandom,
             $urandom};
        if ($urandom_range(0, 99) < 15)
            return c;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.op = OP_TICK;
        else if (pick < 57)
            c.op = OP_SETUP;
        else if (pick < 70)
            c.op = OP_DELAY_ONE;
        else if (pick < 78)
            c.op = OP_DELAY_ALL;
        else if (pick < 89)
            c.op = OP_STOP;
        else
            c.op = OP_RESTART;
        if (c.op == OP_TICK)
        begin
            if ($urandom_range(0, 19) == 0)
                run_now = $urandom;
            else
                run_now = run_now + $urandom_range(0, 60);
        end
        c.now_us = run_now;
        if ($urandom_range(0, 9) != 0)
        begin
            c.period_us = $urandom_range(0, 80);
            c.late_us = $urandom_range(0, 100);
        end
        case ($urandom_range(0, 9))
            0: c.delay_us = '0;
            1: c.delay_us = tm_limit;
            2: c.delay_us = tm_limit + 1;
            3: c.delay_us = $urandom;
            default:
            begin
                c.delay_us = $urandom_range(1, 100);
                if (c.delay_us > tm_limit)
                    c.delay_us = tm_limit;
            end
        endcase
        return c;
    endfunction

    // Stimulus
    initial
    begin
        logic [31:0] limits [5];
        cmd_t c;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tm_mode[i] = MODE_READY;
            tm_reg[i] = 1'b0;
            tm_period[i] = '0;
            tm_late[i] = '0;
            tm_last[i] = '0;
        end
        tm_limit = DELAY_LIMIT_RESET;

        // Directed table under the reset delay limit
        add_row(OP_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, STATUS_OK);
        add_row(OP_SETUP, 4'd0, 32'd0, 32'd10, 32'd15, 32'd0, 1, STATUS_OK);
        add_row(OP_SETUP, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0, 1, STATUS_OK);
        add_row(OP_SETUP, 4'd7, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'd5, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_DELAY_ONE, 4'd0, 32'd100, 32'd0, 32'd0, 32'd0, 1, STATUS_REJECT);
        add_row(OP_DELAY_ONE, 4'd0, 32'd100, 32'd0, 32'd0, 32'h8000_0000, 1, STATUS_REJECT);
        add_row(OP_DELAY_ONE, 4'd0, 32'd100, 32'd0, 32'd0, 32'h7FFF_FFFF, 1, STATUS_OK);
        add_row(OP_DELAY_ALL, 4'd0, 32'd100, 32'd0, 32'd0, 32'd20, 1, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'd110, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'd120, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_STOP, 4'd15, 32'd125, 32'd0, 32'd0, 32'd0, 1, STATUS_OK);
        add_row(OP_DELAY_ONE, 4'd15, 32'd130, 32'd0, 32'd0, 32'd5, 1, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'd200, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_RESTART, 4'd15, 32'd200, 32'd0, 32'd0, 32'd0, 1, STATUS_OK);
        add_row(OP_DELAY_ONE, 4'd3, 32'd210, 32'd0, 32'd0, 32'd5, 1, STATUS_OK);
        add_row(OP_STOP, 4'd4, 32'd215, 32'd0, 32'd0, 32'd0, 1, STATUS_OK);
        add_row(OP_RESTART, 4'd5, 32'd220, 32'd0, 32'd0, 32'd0, 1, STATUS_OK);
        add_row(OP_SPARE_A, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 0, STATUS_OK);
        add_row(OP_SPARE_B, 4'd6, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 0, STATUS_OK);
        add_row(OP_DELAY_ALL, 4'd0, 32'd300, 32'd0, 32'd0, 32'd0, 1, STATUS_REJECT);
        add_row(OP_SETUP, 4'd0, 32'd0, 32'd3, 32'd1, 32'd0, 1, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'h0000_0010, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);
        add_row(OP_TICK, 4'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, ROW_PREDICTED, STATUS_OK);

        // Hold reset, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].c, dir_rows[r].n, dir_rows[r].st);

        // Random phases, each under its own delay limit
        limits[0] = 32'hFFFF_FFFF;
        limits[1] = 32'd1;
        limits[2] = $urandom_range(200, 2000);
        limits[3] = $urandom | 32'h1;
        limits[4] = DELAY_LIMIT_RESET;
        run_now = 32'h7FFF_FFFF;
        foreach (limits[p])
        begin
            write_delay_limit(limits[p]);
            steady = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 16 == 15)
                    steady = ($urandom_range(0, 3) == 0);
                c = random_cmd();
                // Open each phase by registering a handful of timers
                if (n < 6)
                begin
                    c.op = OP_SETUP;
                    c.period_us = $urandom_range(0, 40);
                    c.late_us = $urandom_range(0, 60);
                end
                send_item(c, ROW_PREDICTED, STATUS_OK);
            end
        end

        // Drain and let the block go quiet
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    function automatic bit field_ok(input string name, input logic [3:0] want,
                                    input logic [3:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    // Check each result beat against the oldest expectation, and stall at random
    always @(posedge clk)
    begin : rx_check
        beat_t want;
        beat_t got;
        bit ok;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[5], m_tlast};
                if (pending_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    ok = field_ok("kind", 4'(want.kind), 4'(got.kind));
                    ok &= field_ok("fired_index", want.idx, got.idx);
                    ok &= field_ok("timed_out", 4'(want.timed_out), 4'(got.timed_out));
                    ok &= field_ok("status", 4'(want.status), 4'(got.status));
                    ok &= field_ok("last", 4'(want.last), 4'(got.last));
                    if (!ok)
                        fail_count++;
                end
                rx_wait = steady ? 0 : $urandom_range(0, 13);
                m_tready <= (rx_wait == 0);
            end
            else if (!m_tready)
            begin
                if (rx_wait <= 1)
                    m_tready <= 1'b1;
                rx_wait = rx_wait - 1;
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ptb_pkg.sv
rtl/ptb_timer_store.sv
rtl/ptb_entry_eval.sv
rtl/periodic_timer_bank.sv
sim/tb_top.sv
